[src/delta_modulation_sample_channel_core_defines.svh]
// Assertion macros shared by the delta-modulation sample channel RTL.
`ifndef DELTA_MODULATION_SAMPLE_CHANNEL_CORE_DEFINES_SVH
`define DELTA_MODULATION_SAMPLE_CHANNEL_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define DMSC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define DMSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/dmsc_pkg.sv]
// Shared types and constants for the delta-modulation sample channel.
package dmsc_pkg;

  localparam logic [15:0] ADDR_TOP       = 16'hFFFF;
  localparam logic [15:0] ADDR_WRAP      = 16'h8000;
  localparam logic [6:0]  LEVEL_RISE_MAX = 7'd125;
  localparam logic [6:0]  LEVEL_STEP     = 7'd2;
  localparam logic [3:0]  BITS_PER_BYTE  = 4'd8;

  // Configuration register indexes
  localparam logic [2:0] CFG_TIMER_RELOAD  = 3'd0;
  localparam logic [2:0] CFG_START_ADDRESS = 3'd1;
  localparam logic [2:0] CFG_SAMPLE_LENGTH = 3'd2;
  localparam logic [2:0] CFG_LOOP_ENABLE   = 3'd3;
  localparam logic [2:0] CFG_IRQ_ENABLE    = 3'd4;

  // Reset values of the configuration registers
  localparam logic [7:0]  RST_TIMER_RELOAD  = 8'd213;
  localparam logic [15:0] RST_START_ADDRESS = 16'hC000;
  localparam logic [11:0] RST_SAMPLE_LENGTH = 12'd1;

  typedef struct packed {
    logic [7:0]  timer_reload;
    logic [15:0] sample_start_address;
    logic [11:0] sample_length;
    logic        loop_enable;
    logic        irq_enable;
  } dmsc_cfg_t;

  typedef struct packed {
    logic [7:0]  rate_timer;
    logic [7:0]  shift_bits;
    logic [3:0]  bits_left;
    logic [7:0]  buffer_byte;
    logic        buffer_valid;
    logic        silent;
    logic [6:0]  level;
    logic [11:0] bytes_left;
    logic [15:0] read_address;
    logic        irq_flag;
  } dmsc_state_t;

  typedef struct packed {
    logic [6:0]  sample_out;
    logic        irq_pending;
    logic [15:0] fetch_address;
    logic        byte_taken;
  } dmsc_result_t;

endpackage

[src/delta_modulation_sample_channel_core.sv]
// Top level of the delta-modulation sample channel.
//
// Input channel (in_valid / in_stall): one transaction is one clock tick of
// the channel, carrying the fetched memory byte, a start request and an
// interrupt acknowledge. Output channel (out_valid / out_stall): one
// transaction per tick with the level, interrupt flag, next fetch address
// and a flag saying the fetched byte was consumed.
// An accepted tick's result is registered and shown in the next cycle.
// Throughput is one tick per cycle unless the receiver stalls; the whole
// tick update is a single pass of logic into the state and result registers.
// When the receiver stalls, the result register holds and in_stall is raised
// until the result is taken; a new tick is accepted in the same cycle the
// held result leaves.
// The cfg_* port writes one register per cycle at cfg_we; write only while
// idle. Reset (rst, synchronous) restores the register defaults, clears the
// channel state with the channel silent, and empties the output register.
`include "delta_modulation_sample_channel_core_defines.svh"

module delta_modulation_sample_channel_core import dmsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // tick input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  fetched_byte,
  input  logic        start_sample,
  input  logic        irq_ack,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  sample_out,
  output logic        irq_pending,
  output logic [15:0] fetch_address,
  output logic        byte_taken
);

  dmsc_cfg_t    cfg;
  dmsc_state_t  st;
  dmsc_state_t  st_next;
  dmsc_result_t res;
  dmsc_result_t res_next;
  logic         in_fire;

  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timer_reload         <= RST_TIMER_RELOAD;
      cfg.sample_start_address <= RST_START_ADDRESS;
      cfg.sample_length        <= RST_SAMPLE_LENGTH;
      cfg.loop_enable          <= 1'b0;
      cfg.irq_enable           <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMER_RELOAD:  cfg.timer_reload         <= cfg_data[7:0];
        CFG_START_ADDRESS: cfg.sample_start_address <= cfg_data;
        CFG_SAMPLE_LENGTH: cfg.sample_length        <= cfg_data[11:0];
        CFG_LOOP_ENABLE:   cfg.loop_enable          <= cfg_data[0];
        CFG_IRQ_ENABLE:    cfg.irq_enable           <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dmsc_step u_step (
    .cfg          (cfg),
    .st           (st),
    .fetched_byte (fetched_byte),
    .start_sample (start_sample),
    .irq_ack      (irq_ack),
    .st_next      (st_next),
    .res_next     (res_next)
  );

  // channel state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      st.rate_timer   <= 8'd0;
      st.shift_bits   <= 8'd0;
      st.bits_left    <= 4'd0;
      st.buffer_byte  <= 8'd0;
      st.buffer_valid <= 1'b0;
      st.silent       <= 1'b1;
      st.level        <= 7'd0;
      st.bytes_left   <= 12'd0;
      st.read_address <= ADDR_WRAP;
      st.irq_flag     <= 1'b0;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res <= res_next;
    end
  end

  assign sample_out    = res.sample_out;
  assign irq_pending   = res.irq_pending;
  assign fetch_address = res.fetch_address;
  assign byte_taken    = res.byte_taken;

  // checks
  `DMSC_ASSERT_ALWAYS(a_bits_range, st.bits_left <= BITS_PER_BYTE,
    "bit counter out of range")
  `DMSC_ASSERT_ALWAYS(a_addr_match, !out_valid || (fetch_address == st.read_address),
    "shown fetch address differs from reader address")
  `DMSC_ASSERT_ALWAYS(a_taken_buf, !(out_valid && byte_taken) || st.buffer_valid,
    "byte reported taken but buffer empty")
  `DMSC_ASSERT_NEXT(a_hold_state, out_valid && out_stall, $stable(st),
    "channel state moved while result stalled")
  `DMSC_ASSERT_NEXT(a_fire_valid, in_fire, out_valid,
    "accepted tick produced no result")

endmodule

[src/dmsc_step.sv]
// Next-state and result logic for one channel tick.
module dmsc_step import dmsc_pkg::*; (
  input  dmsc_cfg_t    cfg,
  input  dmsc_state_t  st,
  input  logic [7:0]   fetched_byte,
  input  logic         start_sample,
  input  logic         irq_ack,
  output dmsc_state_t  st_next,
  output dmsc_result_t res_next
);

  dmsc_state_t s;
  logic        taken;
  logic [11:0] bytes_dec;

  always_comb begin
    s     = st;
    taken = 1'b0;
    bytes_dec = 12'd0;

    // acknowledge first, then start request
    if (irq_ack) begin
      s.irq_flag = 1'b0;
    end
    if (start_sample && (s.bytes_left == 12'd0)) begin
      s.read_address = cfg.sample_start_address;
      s.bytes_left   = cfg.sample_length;
    end

    // rate timer and output unit
    if (s.rate_timer == 8'd0) begin
      if (!s.silent) begin
        if (s.shift_bits[0]) begin
          if (s.level <= LEVEL_RISE_MAX) begin
            s.level = s.level + LEVEL_STEP;
          end
        end else if (s.level >= LEVEL_STEP) begin
          s.level = s.level - LEVEL_STEP;
        end
      end
      s.shift_bits = {1'b0, s.shift_bits[7:1]};
      if (s.bits_left != 4'd0) begin
        s.bits_left = s.bits_left - 4'd1;
      end
      // new output cycle: reload shifter from the buffer or go quiet
      if (s.bits_left == 4'd0) begin
        s.bits_left = BITS_PER_BYTE;
        if (!s.buffer_valid) begin
          s.silent = 1'b1;
        end else begin
          s.silent       = 1'b0;
          s.shift_bits   = s.buffer_byte;
          s.buffer_valid = 1'b0;
        end
      end
      s.rate_timer = cfg.timer_reload;
    end else begin
      s.rate_timer = s.rate_timer - 8'd1;
    end

    // memory reader refill
    if (!s.buffer_valid && (s.bytes_left != 12'd0)) begin
      taken          = 1'b1;
      s.buffer_byte  = fetched_byte;
      s.buffer_valid = 1'b1;
      s.read_address = (s.read_address == ADDR_TOP) ? ADDR_WRAP : s.read_address + 16'd1;
      bytes_dec      = s.bytes_left - 12'd1;
      s.bytes_left   = bytes_dec;
      if (bytes_dec == 12'd0) begin
        if (cfg.loop_enable) begin
          s.read_address = cfg.sample_start_address;
          s.bytes_left   = cfg.sample_length;
        end else if (cfg.irq_enable) begin
          s.irq_flag = 1'b1;
        end
      end
    end

    st_next                = s;
    res_next.sample_out    = s.silent ? 7'd0 : s.level;
    res_next.irq_pending   = s.irq_flag;
    res_next.fetch_address = s.read_address;
    res_next.byte_taken    = taken;
  end

endmodule
